// File: design/phase_angle_dimmer_assert.svh
// ----------------------------------------------------------------------------
// phase angle dimmer assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PHASE_ANGLE_DIMMER_ASSERT_SVH
`define PHASE_ANGLE_DIMMER_ASSERT_SVH

// same-cycle implication
`define PAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pad_pkg.sv
// ----------------------------------------------------------------------------
// pad_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package pad_pkg;

  localparam int CMD_W      = 2;
  localparam int CHAN_W     = 3;
  localparam int LEVEL_W    = 10;
  localparam int TIME_W     = 15;
  localparam int PULSE_W    = 8;
  localparam int MASK_W     = 8;
  localparam int GATE_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int SHAPE_SUM_W  = LEVEL_W + 2;
  localparam int SHAPE_PROD_W = LEVEL_W + SHAPE_SUM_W;
  localparam int SHAPE_SHIFT  = 11;
  localparam int SHAPED_W     = SHAPE_PROD_W - SHAPE_SHIFT;
  localparam int SCALE_PROD_W = LEVEL_W + TIME_W;
  localparam int SCALE_SHIFT  = 10;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ZERO = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd3;

  localparam logic [TIME_W-1:0]  START_RST = 15'd2000;
  localparam logic [TIME_W-1:0]  END_RST   = 15'd9000;
  localparam logic [PULSE_W-1:0] PULSE_RST = 8'd2;
  localparam logic [MASK_W-1:0]  MASK_RST  = 8'd0;

  localparam logic [LEVEL_W-1:0]     LEVEL_MAX    = 10'd1023;
  localparam logic [SHAPE_SUM_W-1:0] SHAPE_OFFSET = 12'd1025;
  localparam logic [COUNT_W-1:0]     COUNT_SAT    = 16'hFFFF;

  typedef struct packed {
    logic cap;
    logic exec_tick;
    logic exec_zero;
    logic exec_set;
    logic mul_shape;
    logic mul_scale;
    logic wr_fire;
    logic cmp;
    logic out_load;
  } pad_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             zero_ok;
    logic             last_ch;
  } pad_status_t;

endpackage

// File: design/pad_ctrl.sv
// ----------------------------------------------------------------------------
// pad_ctrl
// sequencer for one item at a time: decode, per-channel fire time steps,
// comparator pass and output register load
// ----------------------------------------------------------------------------
module pad_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pad_pkg::pad_status_t status,
  output pad_pkg::pad_cmd_t    cmd
);
  import pad_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SHAPE = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.cmd)
          CMD_TICK: begin
            cmd.exec_tick = 1'b1;
            state_nxt     = S_CMP;
          end
          CMD_ZERO: begin
            if (status.zero_ok) begin
              cmd.exec_zero = 1'b1;
              state_nxt     = S_SHAPE;
            end else begin
              state_nxt = S_DONE;
            end
          end
          CMD_SET: begin
            cmd.exec_set = 1'b1;
            state_nxt    = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHAPE: begin
        cmd.mul_shape = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_scale = 1'b1;
        state_nxt     = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_fire = 1'b1;
        state_nxt   = status.last_ch ? S_CMP : S_SHAPE;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/pad_dp.sv
// ----------------------------------------------------------------------------
// pad_dp
// registers, level stores, shared multiplier path for fire times and
// per-channel fire and release comparators
// ----------------------------------------------------------------------------
module pad_dp #(
  parameter int CHANNELS     = 8,
  parameter int ZERO_LOCKOUT = 2000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pad_pkg::pad_cmd_t                cmd,
  output pad_pkg::pad_status_t             status,
  input  logic [pad_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pad_pkg::CHAN_W-1:0]       in_channel,
  input  logic [pad_pkg::LEVEL_W-1:0]      in_level,
  input  logic                             cfg_wr_en,
  input  logic [pad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [pad_pkg::GATE_W-1:0]       out_gate_levels,
  output logic                             out_zero_accepted
);
  import pad_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [CHAN_W-1:0]       chan_r, chan_nxt;
  logic [LEVEL_W-1:0]      level_r, level_nxt;
  logic [TIME_W-1:0]       start_r, start_nxt;
  logic [TIME_W-1:0]       end_r, end_nxt;
  logic [PULSE_W-1:0]      pulse_r, pulse_nxt;
  logic [MASK_W-1:0]       mask_r, mask_nxt;
  logic [COUNT_W-1:0]      elapsed_r, elapsed_nxt;
  logic                    plan_r, plan_nxt;
  logic                    acc_r, acc_nxt;
  logic [TIME_W-1:0]       span_r, span_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [SHAPE_PROD_W-1:0] shape_prod_r, shape_prod_nxt;
  logic [SCALE_PROD_W-1:0] scale_prod_r, scale_prod_nxt;
  logic [LEVEL_W-1:0]      pending_r [CHANNELS];
  logic [LEVEL_W-1:0]      pending_nxt [CHANNELS];
  logic [LEVEL_W-1:0]      latched_r [CHANNELS];
  logic [LEVEL_W-1:0]      latched_nxt [CHANNELS];
  logic [TIME_W-1:0]       fire_r [CHANNELS];
  logic [TIME_W-1:0]       fire_nxt [CHANNELS];
  logic [CHANNELS-1:0]     gate_r, gate_nxt;
  logic [GATE_W-1:0]       gate_out_r, gate_out_nxt;
  logic                    zero_out_r, zero_out_nxt;

  logic [CHANNELS-1:0]     mask_ext;
  logic [LEVEL_W-1:0]      cur_level;
  logic [SHAPE_SUM_W-1:0]  shape_sum;
  logic [SHAPED_W-1:0]     shaped;
  logic [LEVEL_W-1:0]      shaped_clamp;
  logic [COUNT_W-1:0]      release_time [CHANNELS];

  assign mask_ext     = CHANNELS'(mask_r);
  assign cur_level    = latched_r[idx_r];
  assign shape_sum    = SHAPE_SUM_W'(cur_level) + SHAPE_OFFSET;
  assign shaped       = shape_prod_r[SHAPE_PROD_W-1:SHAPE_SHIFT];
  assign shaped_clamp = (shaped > SHAPED_W'(LEVEL_MAX)) ? LEVEL_MAX : shaped[LEVEL_W-1:0];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      release_time[i] = COUNT_W'(fire_r[i]) + COUNT_W'(pulse_r);
    end
  end

  assign status.cmd     = cmd_r;
  assign status.zero_ok = (elapsed_r >= COUNT_W'(ZERO_LOCKOUT));
  assign status.last_ch = (idx_r == CW'(CHANNELS - 1));

  always_comb begin
    cmd_nxt        = cmd_r;
    chan_nxt       = chan_r;
    level_nxt      = level_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    pulse_nxt      = pulse_r;
    mask_nxt       = mask_r;
    elapsed_nxt    = elapsed_r;
    plan_nxt       = plan_r;
    acc_nxt        = acc_r;
    span_nxt       = span_r;
    idx_nxt        = idx_r;
    shape_prod_nxt = shape_prod_r;
    scale_prod_nxt = scale_prod_r;
    pending_nxt    = pending_r;
    latched_nxt    = latched_r;
    fire_nxt       = fire_r;
    gate_nxt       = gate_r;
    gate_out_nxt   = gate_out_r;
    zero_out_nxt   = zero_out_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START: start_nxt = cfg_wdata[TIME_W-1:0];
        CFG_END:   end_nxt   = cfg_wdata[TIME_W-1:0];
        CFG_PULSE: pulse_nxt = cfg_wdata[PULSE_W-1:0];
        CFG_MASK:  mask_nxt  = cfg_wdata[MASK_W-1:0];
        default:   mask_nxt  = mask_r;
      endcase
    end

    if (cmd.cap) begin
      cmd_nxt   = in_cmd;
      chan_nxt  = in_channel;
      level_nxt = in_level;
      acc_nxt   = 1'b0;
    end

    if (cmd.exec_tick) begin
      if (elapsed_r != COUNT_SAT) begin
        elapsed_nxt = elapsed_r + COUNT_W'(1);
      end
      if (elapsed_nxt == COUNT_SAT) begin
        plan_nxt = 1'b0;
      end
    end

    if (cmd.exec_set) begin
      if (int'(chan_r) < CHANNELS) begin
        pending_nxt[CW'(chan_r)] = level_r;
      end
    end

    if (cmd.exec_zero) begin
      elapsed_nxt = '0;
      plan_nxt    = 1'b1;
      acc_nxt     = 1'b1;
      idx_nxt     = '0;
      span_nxt    = (end_r >= start_r) ? (end_r - start_r) : '0;
      latched_nxt = pending_r;
      gate_nxt    = gate_r & mask_ext;
    end

    if (cmd.mul_shape) begin
      shape_prod_nxt = SHAPE_PROD_W'(cur_level) * SHAPE_PROD_W'(shape_sum);
    end

    if (cmd.mul_scale) begin
      scale_prod_nxt = SCALE_PROD_W'(shaped_clamp) * SCALE_PROD_W'(span_r);
    end

    if (cmd.wr_fire) begin
      fire_nxt[idx_r] = end_r - scale_prod_r[SCALE_PROD_W-1:SCALE_SHIFT];
      if (!status.last_ch) begin
        idx_nxt = idx_r + CW'(1);
      end
    end

    // fire first, release second so a zero pulse length releases unless the level is full
    if (cmd.cmp && plan_r) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (mask_ext[i]) begin
          if (elapsed_r == COUNT_W'(fire_r[i])) begin
            gate_nxt[i] = (latched_r[i] != '0);
          end
          if (elapsed_r == release_time[i]) begin
            gate_nxt[i] = (latched_r[i] == LEVEL_MAX);
          end
        end
      end
    end

    if (cmd.out_load) begin
      gate_out_nxt = GATE_W'(gate_r);
      zero_out_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= START_RST;
      end_r     <= END_RST;
      pulse_r   <= PULSE_RST;
      mask_r    <= MASK_RST;
      elapsed_r <= COUNT_SAT;
      plan_r    <= 1'b0;
      acc_r     <= 1'b0;
      idx_r     <= '0;
      gate_r    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pending_r[i] <= '0;
        latched_r[i] <= '0;
        fire_r[i]    <= '0;
      end
    end else begin
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      pulse_r   <= pulse_nxt;
      mask_r    <= mask_nxt;
      elapsed_r <= elapsed_nxt;
      plan_r    <= plan_nxt;
      acc_r     <= acc_nxt;
      idx_r     <= idx_nxt;
      gate_r    <= gate_nxt;
      pending_r <= pending_nxt;
      latched_r <= latched_nxt;
      fire_r    <= fire_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    chan_r       <= chan_nxt;
    level_r      <= level_nxt;
    span_r       <= span_nxt;
    shape_prod_r <= shape_prod_nxt;
    scale_prod_r <= scale_prod_nxt;
    gate_out_r   <= gate_out_nxt;
    zero_out_r   <= zero_out_nxt;
  end

  assign out_gate_levels   = gate_out_r;
  assign out_zero_accepted = zero_out_r;

endmodule

// File: design/phase_angle_dimmer.sv
// ----------------------------------------------------------------------------
// phase_angle_dimmer: one item in flight, result held in an output register
// steps per item: decode and compare pass for a tick, decode only for a level
// write or rejected crossing, decode, 3 steps per channel on one multiply path
// and compare pass for an accepted crossing; each then loads the output register
// reset (sync, rst_n low) clears levels and gates, saturates the count
// ----------------------------------------------------------------------------
`include "phase_angle_dimmer_assert.svh"

module phase_angle_dimmer #(
  parameter int CHANNELS     = 8,
  parameter int ZERO_LOCKOUT = 2000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pad_pkg::CMD_W-1:0]      in_cmd,
  input  logic [pad_pkg::CHAN_W-1:0]     in_channel,
  input  logic [pad_pkg::LEVEL_W-1:0]    in_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pad_pkg::GATE_W-1:0]     out_gate_levels,
  output logic                           out_zero_accepted,
  input  logic                           cfg_wr_en,
  input  logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pad_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pad_pkg::*;

  pad_cmd_t    ctl_cmd;
  pad_status_t ctl_status;

  pad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (ctl_status),
    .cmd       (ctl_cmd)
  );

  pad_dp #(
    .CHANNELS     (CHANNELS),
    .ZERO_LOCKOUT (ZERO_LOCKOUT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctl_cmd),
    .status            (ctl_status),
    .in_cmd            (in_cmd),
    .in_channel        (in_channel),
    .in_level          (in_level),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_gate_levels   (out_gate_levels),
    .out_zero_accepted (out_zero_accepted)
  );

  `PAD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not blocked")
  `PAD_ASSERT_SAME(a_cap_on_accept, ctl_cmd.cap, in_valid && !in_stall, "cap without handshake")
  `PAD_ASSERT_SAME(a_no_overwrite, ctl_cmd.out_load, !out_valid || !out_stall, "result lost")
  `PAD_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0(ctl_cmd), "datapath commands overlap")

endmodule
